// ----- rtl/matrix3_inverse_core_assert.svh -----
// Assertion macros for the 3x3 matrix inverse core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MATRIX3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/m3i_pkg.sv -----
// Shared constants for the 3x3 matrix inverse core.
// No dependencies; imported by every RTL module of the block.
package m3i_pkg;

    localparam int N_ENT = 9;
    localparam int N_ROW = 3;

    // Cofactor k = ent[CF_PA[k]] * ent[CF_PB[k]] - ent[CF_PC[k]] * ent[CF_PD[k]]
    // (entries in row order, adjugate in row order)
    localparam int CF_PA [N_ENT] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int CF_PB [N_ENT] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int CF_PC [N_ENT] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int CF_PD [N_ENT] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    // Determinant by first row: sum of ent[k] * adj[DET_ADJ[k]]
    localparam int DET_ADJ [N_ROW] = '{0, 3, 6};

endpackage

// ----- rtl/m3i_front.sv -----
// Cofactor and determinant pipeline for the 3x3 matrix inverse core.
// Depends on m3i_pkg; six register stages, advanced by en.
module m3i_front import m3i_pkg::*; #(
    parameter int EB = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [EB-1:0]  ent [N_ENT],
    output logic signed [2*EB:0]  adj [N_ENT],
    output logic [3*EB:0]         det_mag,
    output logic                  det_neg
);

    localparam int PW  = 2 * EB;
    localparam int AW  = 2 * EB + 1;
    localparam int PPW = 2 * EB + 1;
    localparam int DW  = 3 * EB + 2;
    localparam int DMW = 3 * EB + 1;
    localparam int ADJ_DLY = 5;

    logic signed [PW-1:0]  pa_reg [N_ENT];
    logic signed [PW-1:0]  pb_reg [N_ENT];
    logic signed [EB-1:0]  row_reg [2][N_ROW];
    logic signed [AW-1:0]  adj_reg [ADJ_DLY][N_ENT];
    logic signed [PPW-1:0] phi_reg [N_ROW];
    logic signed [PPW-1:0] plo_reg [N_ROW];
    logic signed [DW-1:0]  term_reg [N_ROW];
    logic signed [DW-1:0]  det_reg;
    logic [DMW-1:0]        det_mag_reg;
    logic                  det_neg_reg;

    logic signed [EB:0]    hi_op [N_ROW];
    logic signed [EB:0]    lo_op [N_ROW];
    logic signed [DW-1:0]  det_abs;

    // Split each first-row cofactor into a signed high and unsigned low half
    always_comb
    begin
        for (int k = 0; k < N_ROW; k++)
        begin
            hi_op[k] = $signed(adj_reg[0][DET_ADJ[k]][AW-1:EB]);
            lo_op[k] = $signed({1'b0, adj_reg[0][DET_ADJ[k]][EB-1:0]});
        end
        det_abs = det_reg[DW-1] ? -det_reg : det_reg;
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                pa_reg[i] <= PW'(ent[CF_PA[i]]) * PW'(ent[CF_PB[i]]);
                pb_reg[i] <= PW'(ent[CF_PC[i]]) * PW'(ent[CF_PD[i]]);
                adj_reg[0][i] <= AW'(pa_reg[i]) - AW'(pb_reg[i]);
                for (int j = 1; j < ADJ_DLY; j++)
                begin
                    adj_reg[j][i] <= adj_reg[j-1][i];
                end
            end
            for (int k = 0; k < N_ROW; k++)
            begin
                row_reg[0][k] <= ent[k];
                row_reg[1][k] <= row_reg[0][k];
                phi_reg[k] <= PPW'(row_reg[1][k]) * PPW'(hi_op[k]);
                plo_reg[k] <= PPW'(row_reg[1][k]) * PPW'(lo_op[k]);
                term_reg[k] <= (DW'(phi_reg[k]) <<< EB) + DW'(plo_reg[k]);
            end
            det_reg     <= term_reg[0] + term_reg[1] + term_reg[2];
            det_neg_reg <= det_reg[DW-1];
            det_mag_reg <= det_abs[DMW-1:0];
        end
    end

    assign adj     = adj_reg[ADJ_DLY-1];
    assign det_mag = det_mag_reg;
    assign det_neg = det_neg_reg;

endmodule

// ----- rtl/m3i_div_lane.sv -----
// One divider lane: adjugate entry over determinant, one quotient bit a stage.
// Depends on m3i_pkg; EB+1 register stages, divisor pipeline held by the top.
module m3i_div_lane import m3i_pkg::*; #(
    parameter int EB = 32,
    parameter int FB = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [2*EB:0]  adj,
    input  logic [3*EB:0]         det_mag,
    input  logic                  det_neg,
    input  logic [3*EB:0]         d_stage [EB],
    output logic signed [EB-1:0]  quo
);

    localparam int AW  = 2 * EB + 1;
    localparam int AMW = 2 * EB;
    localparam int NW  = AMW + 2 * FB;
    localparam int HW  = NW - EB;
    localparam int DMW = 3 * EB + 1;
    localparam int CW  = (HW > DMW) ? HW : DMW;

    logic [DMW-1:0] rem_reg [EB+1];
    logic [EB-1:0]  q_reg   [EB+1];
    logic [EB-1:0]  nlo_reg [EB+1];
    logic [EB:0]    neg_reg;
    logic [EB:0]    ovf_reg;

    logic [AW-1:0]  a_abs;
    logic [NW-1:0]  num;
    logic [CW-1:0]  nhi_ext;
    logic           ovf_next;
    logic [DMW:0]   r2   [EB];
    logic [DMW:0]   diff [EB];
    logic [EB-1:0]  ge;
    logic [EB-1:0]  lim_pos;
    logic [EB-1:0]  lim_neg;
    logic [EB-1:0]  mag;

    // Scale the numerator and flag quotients that cannot fit EB bits
    always_comb
    begin
        a_abs    = adj[AW-1] ? AW'(-adj) : AW'(adj);
        num      = {a_abs[AMW-1:0], {(2*FB){1'b0}}};
        nhi_ext  = CW'(num[NW-1:EB]);
        ovf_next = nhi_ext >= CW'(det_mag);
    end

    // Restoring step per stage
    always_comb
    begin
        for (int k = 0; k < EB; k++)
        begin
            r2[k]   = {rem_reg[k], nlo_reg[k][EB-1]};
            diff[k] = r2[k] - {1'b0, d_stage[k]};
            ge[k]   = r2[k] >= {1'b0, d_stage[k]};
        end
    end

    // Load the first stage and advance the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nhi_ext[DMW-1:0];
            q_reg[0]   <= '0;
            nlo_reg[0] <= num[EB-1:0];
            neg_reg[0] <= adj[AW-1] ^ det_neg;
            ovf_reg[0] <= ovf_next;
            for (int k = 0; k < EB; k++)
            begin
                rem_reg[k+1] <= ge[k] ? diff[k][DMW-1:0] : r2[k][DMW-1:0];
                q_reg[k+1]   <= {q_reg[k][EB-2:0], ge[k]};
                nlo_reg[k+1] <= {nlo_reg[k][EB-2:0], 1'b0};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Saturate to the signed entry range and apply the sign
    always_comb
    begin
        lim_pos = {1'b0, {(EB-1){1'b1}}};
        lim_neg = {1'b1, {(EB-1){1'b0}}};
        if (neg_reg[EB])
        begin
            mag = (ovf_reg[EB] || q_reg[EB] > lim_neg) ? lim_neg : q_reg[EB];
        end
        else
        begin
            mag = (ovf_reg[EB] || q_reg[EB] > lim_pos) ? lim_pos : q_reg[EB];
        end
        quo = neg_reg[EB] ? $signed(-mag) : $signed(mag);
    end

endmodule

// ----- rtl/matrix3_inverse_core.sv -----
// Top level of the 3x3 matrix inverse core: front end, nine divider lanes, output merge.
// Depends on m3i_pkg, m3i_front, m3i_div_lane and matrix3_inverse_core_assert.svh.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready  | in_r1c1 .. in_r3c3
//   output  | out       | out_valid / out_ready| out_r1c1 .. out_r3c3, singular
//
// One matrix accepted per cycle while the output is not stalled.
// Depth is set by the nine restoring divider lanes, one quotient bit per stage,
// behind a six-stage cofactor and determinant front end.
// When the output register holds an untaken request, the whole pipeline freezes.
// Reset clears only the valid bits; datapath registers are not reset.
`include "matrix3_inverse_core_assert.svh"

module matrix3_inverse_core import m3i_pkg::*; #(
    parameter int ENTRY_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ENTRY_BITS-1:0] in_r1c1,
    input  logic signed [ENTRY_BITS-1:0] in_r1c2,
    input  logic signed [ENTRY_BITS-1:0] in_r1c3,
    input  logic signed [ENTRY_BITS-1:0] in_r2c1,
    input  logic signed [ENTRY_BITS-1:0] in_r2c2,
    input  logic signed [ENTRY_BITS-1:0] in_r2c3,
    input  logic signed [ENTRY_BITS-1:0] in_r3c1,
    input  logic signed [ENTRY_BITS-1:0] in_r3c2,
    input  logic signed [ENTRY_BITS-1:0] in_r3c3,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ENTRY_BITS-1:0] out_r1c1,
    output logic signed [ENTRY_BITS-1:0] out_r1c2,
    output logic signed [ENTRY_BITS-1:0] out_r1c3,
    output logic signed [ENTRY_BITS-1:0] out_r2c1,
    output logic signed [ENTRY_BITS-1:0] out_r2c2,
    output logic signed [ENTRY_BITS-1:0] out_r2c3,
    output logic signed [ENTRY_BITS-1:0] out_r3c1,
    output logic signed [ENTRY_BITS-1:0] out_r3c2,
    output logic signed [ENTRY_BITS-1:0] out_r3c3,
    output logic                         singular
);

    localparam int EB  = ENTRY_BITS;
    localparam int DMW = 3 * EB + 1;
    localparam int LAT = EB + 7;

    logic                  en;
    logic signed [EB-1:0]  ent [N_ENT];
    logic signed [2*EB:0]  adj [N_ENT];
    logic [DMW-1:0]        det_mag;
    logic                  det_neg;
    logic signed [EB-1:0]  quo [N_ENT];

    logic [DMW-1:0]        d_pipe_reg [EB];
    logic [EB:0]           sing_pipe_reg;
    logic [LAT-1:0]        vld_reg;
    logic                  out_valid_reg;
    logic signed [EB-1:0]  out_reg [N_ENT];
    logic                  sing_reg;

    // Advance whenever the output slot is free or being emptied
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign ent[0] = in_r1c1;
    assign ent[1] = in_r1c2;
    assign ent[2] = in_r1c3;
    assign ent[3] = in_r2c1;
    assign ent[4] = in_r2c2;
    assign ent[5] = in_r2c3;
    assign ent[6] = in_r3c1;
    assign ent[7] = in_r3c2;
    assign ent[8] = in_r3c3;

    m3i_front #(.EB(EB)) u_front (
        .clk     (clk),
        .en      (en),
        .ent     (ent),
        .adj     (adj),
        .det_mag (det_mag),
        .det_neg (det_neg)
    );

    // Nine divider lanes share the divisor pipeline
    for (genvar g = 0; g < N_ENT; g++)
    begin : g_lane
        m3i_div_lane #(.EB(EB), .FB(FRAC_BITS)) u_lane (
            .clk     (clk),
            .en      (en),
            .adj     (adj[g]),
            .det_mag (det_mag),
            .det_neg (det_neg),
            .d_stage (d_pipe_reg),
            .quo     (quo[g])
        );
    end

    // Carry divisor and singular flag alongside the lanes; merge into the output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_pipe_reg[0]    <= det_mag;
            sing_pipe_reg[0] <= det_mag == '0;
            for (int k = 1; k < EB; k++)
            begin
                d_pipe_reg[k] <= d_pipe_reg[k-1];
            end
            for (int k = 1; k <= EB; k++)
            begin
                sing_pipe_reg[k] <= sing_pipe_reg[k-1];
            end
            for (int i = 0; i < N_ENT; i++)
            begin
                out_reg[i] <= sing_pipe_reg[EB] ? '0 : quo[i];
            end
            sing_reg <= sing_pipe_reg[EB];
        end
    end

    // Track which stages hold a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_r1c1  = out_reg[0];
    assign out_r1c2  = out_reg[1];
    assign out_r1c3  = out_reg[2];
    assign out_r2c1  = out_reg[3];
    assign out_r2c2  = out_reg[4];
    assign out_r2c3  = out_reg[5];
    assign out_r3c1  = out_reg[6];
    assign out_r3c2  = out_reg[7];
    assign out_r3c3  = out_reg[8];
    assign singular  = sing_reg;

    `M3I_ASSERT_NOW(a_sing_zero, out_valid && singular, out_reg[0] == '0 && out_reg[4] == '0 && out_reg[8] == '0 && out_reg[2] == '0, "singular result with nonzero entry")
    `M3I_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    `M3I_ASSERT_NEXT(a_freeze, !en, $stable(vld_reg), "pipeline moved during stall")
    `M3I_ASSERT_NOW(a_rise_src, $rose(out_valid), $past(vld_reg[LAT-1]), "result with no request in flight")

endmodule
